// ----- rtl/core/dynamic_adjacency_edge_store_defines.svh -----
// assertion macros shared by the edge store rtl
`ifndef DYNAMIC_ADJACENCY_EDGE_STORE_DEFINES_SVH
`define DYNAMIC_ADJACENCY_EDGE_STORE_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define DAES_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition must never be seen outside reset
`define DAES_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`else

`define DAES_ASSERT(name, prop, msg)

`define DAES_ASSERT_NEVER(name, cond, msg)

`endif

`endif

// ----- rtl/core/daes_pkg.sv -----
// shared types and constants of the adjacency edge store
`default_nettype none

package daes_pkg;

    localparam int NODE_W    = 10;
    localparam int FUNC_W    = 2;
    localparam int CHANGED_W = 2;
    localparam int SDEG_W    = 5;
    localparam int TOTAL_W   = 15;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [NODE_W-1:0] src_id;
        logic [NODE_W-1:0] dst_id;
    } daes_in_t;

    typedef struct packed {
        logic [CHANGED_W-1:0] edges_changed;
        logic                 edge_present;
        logic                 list_full;
        logic                 self_loop;
        logic [SDEG_W-1:0]    source_degree;
        logic [TOTAL_W-1:0]   edge_total;
    } daes_out_t;

    typedef struct packed {
        logic              start;
        logic [NODE_W-1:0] target;
    } daes_scan_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } daes_scan_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/daes_ram.sv -----
// generic simple dual port ram with registered read
`default_nettype none

module daes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/daes_scan.sv -----
// neighbor list scanner: one slot read and compare per cycle
`default_nettype none

module daes_scan #(
    parameter int NODE_COUNT = 1024,
    parameter int MAX_DEGREE = 16,
    localparam int NA_W   = $clog2(NODE_COUNT),
    localparam int SLOT_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1,
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  daes_pkg::daes_scan_cmd_t        cmd,
    input  logic [NA_W-1:0]                 node_addr,
    input  logic [DEG_W-1:0]                count,
    output logic [NA_W+SLOT_W-1:0]          rd_addr,
    input  logic [daes_pkg::NODE_W-1:0]     rd_data,
    output daes_pkg::daes_scan_sts_t        sts,
    output logic [SLOT_W-1:0]               slot
);

    logic                        busy_reg;
    logic                        done_reg;
    logic                        found_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic [NA_W-1:0]             node_reg;
    logic [daes_pkg::NODE_W-1:0] target_reg;
    logic [DEG_W-1:0]            count_reg;
    logic [DEG_W-1:0]            issue_reg;
    logic                        chk_valid_reg;
    logic [SLOT_W-1:0]           chk_slot_reg;

    logic match;
    logic more;

    // the shared compare unit: returned entry against target, issue index against count
    assign match = chk_valid_reg && (rd_data == target_reg);
    assign more  = issue_reg < count_reg;

    assign rd_addr = {node_reg, issue_reg[SLOT_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            chk_valid_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg      <= 1'b1;
                node_reg      <= node_addr;
                target_reg    <= cmd.target;
                count_reg     <= count;
                issue_reg     <= '0;
                chk_valid_reg <= 1'b0;
            end else if (busy_reg) begin
                if (match) begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    found_reg <= 1'b1;
                    slot_reg  <= chk_slot_reg;
                end else if (more) begin
                    chk_valid_reg <= 1'b1;
                    chk_slot_reg  <= issue_reg[SLOT_W-1:0];
                    issue_reg     <= issue_reg + DEG_W'(1);
                end else begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    found_reg <= 1'b0;
                end
            end
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign sts.found = found_reg;
    assign slot      = slot_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dynamic_adjacency_edge_store.sv -----
// top level of the bounded adjacency list edge store
// Each node owns a neighbor list of at most MAX_DEGREE entries held in one neighbor memory,
// with a per-node degree memory beside it. A request (insert, remove or query of src -> dst)
// is taken only while the block is idle and answered with exactly one result transfer; in
// undirected mode the reverse entry is mirrored. After reset the degree memory is cleared
// node by node, during which no request is taken (configuration writes are). The next
// request is taken in the idle state that follows the loading of a result.
// Request time is set by the list scan, which reads one neighbor slot per cycle through the
// single read port of the neighbor memory and checks it in one shared comparator.
// A finished result sits in an output register, so a new request can start while the
// previous result still waits to be taken; a result only waits on the register when the
// one before it has not yet been taken.
`default_nettype none
`include "dynamic_adjacency_edge_store_defines.svh"

module dynamic_adjacency_edge_store #(
    parameter int NODE_COUNT = 1024,
    parameter int MAX_DEGREE = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: directed_mode
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    // request channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  daes_pkg::daes_in_t   s_data,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output daes_pkg::daes_out_t  m_data
);

    localparam int NA_W      = $clog2(NODE_COUNT);
    localparam int SLOT_W    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
    localparam int NBR_AW    = NA_W + SLOT_W;
    localparam int NBR_DEPTH = NODE_COUNT * (2 ** SLOT_W);
    localparam int TOT_W     = $clog2(NODE_COUNT * MAX_DEGREE + 1);
    localparam int NODE_W    = daes_pkg::NODE_W;
    localparam int SDEG_W    = daes_pkg::SDEG_W;
    localparam int OTOT_W    = daes_pkg::TOTAL_W;

    // sequencer states
    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DEG_S    = 4'd2;
    localparam logic [3:0] ST_DEG_D    = 4'd3;
    localparam logic [3:0] ST_FWD      = 4'd4;
    localparam logic [3:0] ST_FWD_WAIT = 4'd5;
    localparam logic [3:0] ST_REV_WAIT = 4'd6;
    localparam logic [3:0] ST_INS_S    = 4'd7;
    localparam logic [3:0] ST_INS_D    = 4'd8;
    localparam logic [3:0] ST_DEL_RD   = 4'd9;
    localparam logic [3:0] ST_DEL_WR   = 4'd10;
    localparam logic [3:0] ST_FINISH   = 4'd11;

    logic [3:0]                  state_reg;
    logic [3:0]                  state_next;

    // request and per-request working registers
    daes_pkg::daes_in_t          req_reg;
    logic [DEG_W-1:0]            deg_s_reg;
    logic [DEG_W-1:0]            deg_d_reg;
    logic [SLOT_W-1:0]           pos_reg;
    logic                        side_reg;      // 0 works on src list, 1 on dst list
    logic                        need_rev_reg;
    logic [daes_pkg::CHANGED_W-1:0] changed_reg;
    logic                        present_reg;
    logic                        full_reg;
    logic                        loop_reg;

    // persistent state
    logic [TOT_W-1:0]            total_reg;
    logic [NA_W-1:0]             clr_reg;
    logic                        directed_mode_reg;

    // output register
    logic                        m_valid_reg;
    daes_pkg::daes_out_t         m_data_reg;

    // memory ports
    logic                        deg_we;
    logic [NA_W-1:0]             deg_wr_addr;
    logic [DEG_W-1:0]            deg_wr_data;
    logic [NA_W-1:0]             deg_rd_addr;
    logic [DEG_W-1:0]            deg_rd_data;
    logic                        nbr_we;
    logic [NBR_AW-1:0]           nbr_wr_addr;
    logic [NODE_W-1:0]           nbr_wr_data;
    logic [NBR_AW-1:0]           nbr_rd_addr;
    logic [NODE_W-1:0]           nbr_rd_data;

    // scanner
    daes_pkg::daes_scan_cmd_t    scan_cmd;
    daes_pkg::daes_scan_sts_t    scan_sts;
    logic [NA_W-1:0]             scan_node;
    logic [DEG_W-1:0]            scan_count;
    logic [NBR_AW-1:0]           scan_rd_addr;
    logic [SLOT_W-1:0]           scan_slot;

    // helpers
    logic                        undirected;
    logic                        in_range;
    logic                        accept;
    logic                        out_free;
    logic                        is_insert;
    logic                        is_remove;
    logic [NA_W-1:0]             src_addr;
    logic [NA_W-1:0]             dst_addr;
    logic [NA_W-1:0]             work_node;
    logic [DEG_W-1:0]            work_deg;
    logic [DEG_W-1:0]            work_last;
    logic                        full_fwd;
    logic                        full_rev;
    logic                        rev_scan_from_fwd;
    logic                        rev_scan_from_del;
    logic                        flag_with_change;
    logic                        pair_while_directed;

    assign undirected = !directed_mode_reg;
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign is_insert  = req_reg.func == daes_pkg::FUNC_INSERT;
    assign is_remove  = req_reg.func == daes_pkg::FUNC_REMOVE;

    // out-of-range nodes leave everything untouched
    assign in_range = (32'(s_data.src_id) < 32'(NODE_COUNT)) &&
                      (32'(s_data.dst_id) < 32'(NODE_COUNT));

    assign src_addr  = NA_W'(req_reg.src_id);
    assign dst_addr  = NA_W'(req_reg.dst_id);
    assign work_node = side_reg ? dst_addr : src_addr;
    assign work_deg  = side_reg ? deg_d_reg : deg_s_reg;
    assign work_last = work_deg - DEG_W'(1);

    // insert refusal: src list full, or dst list full when the reverse entry is missing
    assign full_fwd = deg_s_reg >= DEG_W'(MAX_DEGREE);
    assign full_rev = full_fwd || (!scan_sts.found && (deg_d_reg >= DEG_W'(MAX_DEGREE)));

    // reverse scans: after a missed forward hit on insert, or after dropping the src entry
    assign rev_scan_from_fwd = (state_reg == ST_FWD_WAIT) && scan_sts.done && is_insert &&
                               !scan_sts.found && undirected;
    assign rev_scan_from_del = (state_reg == ST_DEL_WR) && !side_reg && undirected;

    assign scan_cmd.start  = (state_reg == ST_FWD) || rev_scan_from_fwd || rev_scan_from_del;
    assign scan_cmd.target = (state_reg == ST_FWD) ? req_reg.dst_id : req_reg.src_id;
    assign scan_node       = (state_reg == ST_FWD) ? src_addr : dst_addr;
    assign scan_count      = (state_reg == ST_FWD) ? deg_s_reg : deg_d_reg;

    // degree memory access
    always_comb begin
        deg_we      = 1'b0;
        deg_wr_addr = src_addr;
        deg_wr_data = '0;
        case (state_reg)
            ST_CLEAR: begin
                deg_we      = 1'b1;
                deg_wr_addr = clr_reg;
            end
            ST_INS_S: begin
                deg_we      = 1'b1;
                deg_wr_data = deg_s_reg + DEG_W'(1);
            end
            ST_INS_D: begin
                deg_we      = 1'b1;
                deg_wr_addr = dst_addr;
                deg_wr_data = deg_d_reg + DEG_W'(1);
            end
            ST_DEL_WR: begin
                deg_we      = 1'b1;
                deg_wr_addr = work_node;
                deg_wr_data = work_last;
            end
            default: begin
            end
        endcase
    end

    assign deg_rd_addr = (state_reg == ST_DEG_D) ? dst_addr : src_addr;

    // neighbor memory access: append on insert, move-last-into-hole on remove
    always_comb begin
        nbr_we      = 1'b0;
        nbr_wr_addr = {src_addr, deg_s_reg[SLOT_W-1:0]};
        nbr_wr_data = req_reg.dst_id;
        case (state_reg)
            ST_INS_S: begin
                nbr_we = 1'b1;
            end
            ST_INS_D: begin
                nbr_we      = 1'b1;
                nbr_wr_addr = {dst_addr, deg_d_reg[SLOT_W-1:0]};
                nbr_wr_data = req_reg.src_id;
            end
            ST_DEL_WR: begin
                nbr_we      = 1'b1;
                nbr_wr_addr = {work_node, pos_reg};
                nbr_wr_data = nbr_rd_data;
            end
            default: begin
            end
        endcase
    end

    // last entry of the working list is fetched in the cycle before the move
    assign nbr_rd_addr = (state_reg == ST_DEL_RD) ? {work_node, work_last[SLOT_W-1:0]}
                                                  : scan_rd_addr;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == NA_W'(NODE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = in_range ? ST_DEG_S : ST_FINISH;
                end
            end
            ST_DEG_S: begin
                state_next = ST_DEG_D;
            end
            ST_DEG_D: begin
                state_next = (req_reg.src_id == req_reg.dst_id) ? ST_FINISH : ST_FWD;
            end
            ST_FWD: begin
                state_next = ST_FWD_WAIT;
            end
            ST_FWD_WAIT: begin
                if (scan_sts.done) begin
                    if (is_insert) begin
                        if (scan_sts.found) begin
                            state_next = ST_FINISH;
                        end else if (undirected) begin
                            state_next = ST_REV_WAIT;
                        end else begin
                            state_next = full_fwd ? ST_FINISH : ST_INS_S;
                        end
                    end else if (is_remove && scan_sts.found) begin
                        state_next = ST_DEL_RD;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_REV_WAIT: begin
                if (scan_sts.done) begin
                    if (is_insert) begin
                        state_next = full_rev ? ST_FINISH : ST_INS_S;
                    end else begin
                        state_next = scan_sts.found ? ST_DEL_RD : ST_FINISH;
                    end
                end
            end
            ST_INS_S: begin
                state_next = need_rev_reg ? ST_INS_D : ST_FINISH;
            end
            ST_INS_D: begin
                state_next = ST_FINISH;
            end
            ST_DEL_RD: begin
                state_next = ST_DEL_WR;
            end
            ST_DEL_WR: begin
                state_next = rev_scan_from_del ? ST_REV_WAIT : ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_reg           <= '0;
            total_reg         <= '0;
            directed_mode_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                directed_mode_reg <= cfg_wdata;
            end

            // load a new result, or drop valid once the waiting one is taken
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + NA_W'(1);
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg      <= s_data;
                        changed_reg  <= '0;
                        present_reg  <= 1'b0;
                        full_reg     <= 1'b0;
                        loop_reg     <= 1'b0;
                        need_rev_reg <= 1'b0;
                        side_reg     <= 1'b0;
                        deg_s_reg    <= '0;
                    end
                end
                ST_DEG_D: begin
                    deg_s_reg <= deg_rd_data;
                    if (req_reg.src_id == req_reg.dst_id) begin
                        loop_reg <= 1'b1;
                    end
                end
                ST_FWD: begin
                    deg_d_reg <= deg_rd_data;
                end
                ST_FWD_WAIT: begin
                    if (scan_sts.done) begin
                        present_reg <= scan_sts.found;
                        pos_reg     <= scan_slot;
                        if (is_insert && !scan_sts.found && !undirected && full_fwd) begin
                            full_reg <= 1'b1;
                        end
                    end
                end
                ST_REV_WAIT: begin
                    if (scan_sts.done) begin
                        if (is_insert) begin
                            need_rev_reg <= !scan_sts.found;
                            if (full_rev) begin
                                full_reg <= 1'b1;
                            end
                        end else begin
                            pos_reg  <= scan_slot;
                            side_reg <= 1'b1;
                        end
                    end
                end
                ST_INS_S: begin
                    deg_s_reg   <= deg_s_reg + DEG_W'(1);
                    total_reg   <= total_reg + TOT_W'(1);
                    changed_reg <= changed_reg + 2'd1;
                end
                ST_INS_D: begin
                    deg_d_reg   <= deg_d_reg + DEG_W'(1);
                    total_reg   <= total_reg + TOT_W'(1);
                    changed_reg <= changed_reg + 2'd1;
                end
                ST_DEL_WR: begin
                    if (side_reg) begin
                        deg_d_reg <= work_last;
                    end else begin
                        deg_s_reg <= work_last;
                    end
                    total_reg   <= total_reg - TOT_W'(1);
                    changed_reg <= changed_reg + 2'd1;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_data_reg.edges_changed   <= changed_reg;
                        m_data_reg.edge_present    <= present_reg;
                        m_data_reg.list_full       <= full_reg;
                        m_data_reg.self_loop       <= loop_reg;
                        m_data_reg.source_degree   <= SDEG_W'(deg_s_reg);
                        // undirected mode counts each mirrored pair once
                        m_data_reg.edge_total      <= undirected ? OTOT_W'(total_reg >> 1)
                                                                 : OTOT_W'(total_reg);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // per-node degree store, cleared by the sweep after reset
    daes_ram #(
        .WIDTH (DEG_W),
        .DEPTH (NODE_COUNT)
    ) u_deg_ram (
        .aclk    (aclk),
        .wr_en   (deg_we),
        .wr_addr (deg_wr_addr),
        .wr_data (deg_wr_data),
        .rd_addr (deg_rd_addr),
        .rd_data (deg_rd_data)
    );

    // neighbor store, one padded row of slots per node; only slots below the degree are compared
    daes_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NBR_DEPTH)
    ) u_nbr_ram (
        .aclk    (aclk),
        .wr_en   (nbr_we),
        .wr_addr (nbr_wr_addr),
        .wr_data (nbr_wr_data),
        .rd_addr (nbr_rd_addr),
        .rd_data (nbr_rd_data)
    );

    daes_scan #(
        .NODE_COUNT (NODE_COUNT),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (scan_cmd),
        .node_addr (scan_node),
        .count     (scan_count),
        .rd_addr   (scan_rd_addr),
        .rd_data   (nbr_rd_data),
        .sts       (scan_sts),
        .slot      (scan_slot)
    );

    // result conditions watched below
    assign flag_with_change    = m_valid && (m_data.list_full || m_data.self_loop) &&
                                 (m_data.edges_changed != 2'd0);
    assign pair_while_directed = m_valid && directed_mode_reg && (m_data.edges_changed == 2'd2);

    // the sequencer always leaves the idle state on a transfer, so ready drops right after it
    `DAES_ASSERT(a_busy_after_accept, accept |=> !s_ready, "ready high after a transfer")

    // the scanner reports completion only for a scan that was running
    `DAES_ASSERT(a_scan_done_from_busy, scan_sts.done |-> $past(scan_sts.busy), "idle scan done")

    // a refused insert or an ignored self-loop never changes any list
    `DAES_ASSERT_NEVER(a_flag_no_change, flag_with_change, "flagged result changed edges")

    // mirrored changes only exist in undirected mode
    `DAES_ASSERT_NEVER(a_directed_single, pair_while_directed, "pair changed in directed mode")

endmodule

`default_nettype wire
